@@ rtl/sms_pkg.sv @@
// Shared constants and types for the sample mean / deviation / stability block.
// No dependencies; imported by sms_calc and sample_mean_stddev_stability_top.
package sms_pkg;

  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned SkipCount  = 12;

  localparam int unsigned CountW  = 13;
  localparam int unsigned SampleW = 24;
  localparam int unsigned SumW    = 37;
  localparam int unsigned SumSqW  = 61;
  localparam int unsigned MeanW   = 40;
  localparam int unsigned SdW     = 40;
  localparam int unsigned StabW   = 48;
  localparam int unsigned ScaleW  = 32;

  localparam logic [ScaleW-1:0] ScaleReset = 32'h0001_0000;

  localparam logic OpPush  = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef struct packed {
    logic [MeanW-1:0] mean;
    logic [SdW-1:0]   std_dev;
    logic [StabW-1:0] stability;
  } sms_res_t;

endpackage

@@ rtl/sms_calc.sv @@
// Window statistics engine: mean, sample deviation and stability from count and sums.
// Bit-serial divider, shift-add multiplier and digit-by-digit square root. Uses sms_pkg.
module sms_calc import sms_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [CountW-1:0]        n_i,
  input  logic signed [SumW-1:0]   sum_i,
  input  logic [SumSqW-1:0]        sumsq_i,
  input  logic [ScaleW-1:0]        scale_i,
  output logic                     done_o,
  output sms_res_t                 res_o
);

  typedef enum logic [7:0] {
    C_IDLE = 8'b0000_0001,
    C_DIVM = 8'b0000_0010,
    C_MULA = 8'b0000_0100,
    C_MULB = 8'b0000_1000,
    C_DIVV = 8'b0001_0000,
    C_SQRT = 8'b0010_0000,
    C_DIVS = 8'b0100_0000,
    C_DONE = 8'b1000_0000
  } calc_state_e;

  calc_state_e state_q, state_d;

  logic [CountW-1:0] n_q, n_d;
  logic              neg_q, neg_d;
  logic [SumW-1:0]   mag_q, mag_d;
  logic [SumSqW-1:0] sumsq_q, sumsq_d;
  logic [23:0]       nn1_q, nn1_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [102:0]      dvd_q, dvd_d;
  logic [32:0]       rem_q, rem_d;
  logic [31:0]       div_q, div_d;
  logic [73:0]       acc_q, acc_d;
  logic [60:0]       mcand_q, mcand_d;
  logic [36:0]       mplr_q, mplr_d;
  logic [73:0]       a_q, a_d;
  logic [79:0]       rad_q, rad_d;
  logic [43:0]       srem_q, srem_d;
  logic [39:0]       root_q, root_d;
  sms_res_t          res_q, res_d;

  // serial step datapaths
  logic [32:0]  rem_s, rem_n;
  logic         div_ge;
  logic [102:0] dvd_n;
  logic [73:0]  acc_n;
  logic [43:0]  srem_s, trial;
  logic         sq_ge;
  logic [43:0]  srem_n;
  logic [39:0]  root_n;
  logic [SdW-1:0] sd_fin;
  logic [73:0]  d_var;
  logic [25:0]  nn1_full;
  logic         last_step;

  assign rem_s  = {rem_q[31:0], dvd_q[102]};
  assign div_ge = rem_s >= {1'b0, div_q};
  assign rem_n  = div_ge ? rem_s - {1'b0, div_q} : rem_s;
  assign dvd_n  = {dvd_q[101:0], div_ge};

  assign acc_n = {acc_q[72:0], 1'b0} + (mplr_q[36] ? {13'b0, mcand_q} : 74'b0);

  assign srem_s = {srem_q[41:0], rad_q[79:78]};
  assign trial  = {2'b0, root_q, 2'b01};
  assign sq_ge  = srem_s >= trial;
  assign srem_n = sq_ge ? srem_s - trial : srem_s;
  assign root_n = {root_q[38:0], sq_ge};

  assign d_var    = (acc_n <= a_q) ? a_q - acc_n : 74'b0;
  assign nn1_full = {13'b0, n_i} * ({13'b0, n_i} - 26'd1);
  assign last_step = cnt_q == 7'd1;
  assign sd_fin    = (state_q == C_SQRT) ? root_n : '0;

  always_comb begin
    state_d = state_q;
    n_d = n_q; neg_d = neg_q; mag_d = mag_q; sumsq_d = sumsq_q; nn1_d = nn1_q;
    cnt_d = cnt_q; dvd_d = dvd_q; rem_d = rem_q; div_d = div_q;
    acc_d = acc_q; mcand_d = mcand_q; mplr_d = mplr_q; a_d = a_q;
    rad_d = rad_q; srem_d = srem_q; root_d = root_q; res_d = res_q;

    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          n_d     = n_i;
          neg_d   = sum_i[SumW-1];
          mag_d   = sum_i[SumW-1] ? SumW'(-sum_i) : sum_i;
          sumsq_d = sumsq_i;
          nn1_d   = nn1_full[23:0];
          dvd_d   = {(sum_i[SumW-1] ? SumW'(-sum_i) : sum_i), 16'b0, 50'b0};
          rem_d   = '0;
          div_d   = {19'b0, n_i};
          cnt_d   = 7'd53;
          state_d = C_DIVM;
        end
      end
      C_DIVM: begin
        dvd_d = dvd_n; rem_d = rem_n; cnt_d = cnt_q - 7'd1;
        if (last_step) begin
          res_d.mean = neg_q ? MeanW'(-dvd_n[39:0]) : dvd_n[39:0];
          res_d.std_dev = '0;
          if (n_q == CountW'(1)) begin
            // single sample: no spread, go straight to stability
            if (scale_i == '0) begin
              res_d.stability = '1;
              state_d = C_DONE;
            end else begin
              dvd_d = {sd_fin, 16'b0, 47'b0};
              div_d = scale_i; rem_d = '0; cnt_d = 7'd56;
              state_d = C_DIVS;
            end
          end else begin
            acc_d = '0; mcand_d = sumsq_q; mplr_d = {n_q, 24'b0};
            cnt_d = 7'd13;
            state_d = C_MULA;
          end
        end
      end
      C_MULA: begin
        acc_d = acc_n; mplr_d = {mplr_q[35:0], 1'b0}; cnt_d = cnt_q - 7'd1;
        if (last_step) begin
          a_d = acc_n;
          acc_d = '0; mcand_d = {24'b0, mag_q}; mplr_d = mag_q;
          cnt_d = 7'd37;
          state_d = C_MULB;
        end
      end
      C_MULB: begin
        acc_d = acc_n; mplr_d = {mplr_q[35:0], 1'b0}; cnt_d = cnt_q - 7'd1;
        if (last_step) begin
          // clamp a negative spread to zero, then scale by 2^32 before dividing
          dvd_d = {d_var[70:0], 32'b0};
          div_d = {8'b0, nn1_q}; rem_d = '0; cnt_d = 7'd103;
          state_d = C_DIVV;
        end
      end
      C_DIVV: begin
        dvd_d = dvd_n; rem_d = rem_n; cnt_d = cnt_q - 7'd1;
        if (last_step) begin
          rad_d = dvd_n[79:0]; srem_d = '0; root_d = '0; cnt_d = 7'd40;
          state_d = C_SQRT;
        end
      end
      C_SQRT: begin
        rad_d = {rad_q[77:0], 2'b0}; srem_d = srem_n; root_d = root_n;
        cnt_d = cnt_q - 7'd1;
        if (last_step) begin
          res_d.std_dev = sd_fin;
          if (scale_i == '0) begin
            res_d.stability = '1;
            state_d = C_DONE;
          end else begin
            dvd_d = {sd_fin, 16'b0, 47'b0};
            div_d = scale_i; rem_d = '0; cnt_d = 7'd56;
            state_d = C_DIVS;
          end
        end
      end
      C_DIVS: begin
        dvd_d = dvd_n; rem_d = rem_n; cnt_d = cnt_q - 7'd1;
        if (last_step) begin
          res_d.stability = (dvd_n[55:48] != 8'b0) ? '1 : dvd_n[47:0];
          state_d = C_DONE;
        end
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; neg_q <= neg_d; mag_q <= mag_d; sumsq_q <= sumsq_d; nn1_q <= nn1_d;
    dvd_q <= dvd_d; rem_q <= rem_d; div_q <= div_d;
    acc_q <= acc_d; mcand_q <= mcand_d; mplr_q <= mplr_d; a_q <= a_d;
    rad_q <= rad_d; srem_q <= srem_d; root_q <= root_d; res_q <= res_d;
  end

  assign done_o = state_q == C_DONE;
  assign res_o  = res_q;

endmodule

@@ rtl/sample_mean_stddev_stability_top.sv @@
// Running mean, sample standard deviation and bias stability of a gyro sample stream.
// Channels: input word (opcode_i, sample_i) under in_valid_i / in_stall_o, result word
// under out_valid_o / out_stall_i, a word moves when valid is high and stall is low.
// Opcode push adds the sample to running sums over all samples and over the tail
// (samples after the first twelve) and gives two result words: window 0, then
// window 1 with last_o set. The tail word has window_valid_o low, stats zero, until
// thirteen samples exist. A push into a full store (4096 samples) gives one word with
// overflow_o and last_o set. Opcode clear empties count and sums and gives no word.
// cfg_we_i / cfg_wdata_i write the scale factor (reset 1.0 in 16.16), kept on clear.
// A new word is taken only once the last one is through. Each window runs through one
// bit-serial engine: 53 divide steps for the mean, 13 + 37 multiply steps, 103 divide
// steps for the variance, 40 square-root steps and 56 divide steps for stability; a
// window of one sample skips the multiply, variance and root, a zero scale skips the
// stability divide. Window 1 runs the engine only once the tail holds data.
// in_stall_o is high while a word is in progress or an overflow word waits. A finished
// result is held in the output register while out_stall_i is high; the engine waits
// until it can be loaded.
// Reset empties the store and the output register and restores the scale factor.
module sample_mean_stddev_stability_top import sms_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ScaleW-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      window_o,
  output logic                      window_valid_o,
  output logic                      overflow_o,
  output logic signed [MeanW-1:0]   mean_o,
  output logic [SdW-1:0]            std_dev_o,
  output logic [StabW-1:0]          stability_o,
  output logic                      last_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b00_0001,
    ST_START0 = 6'b00_0010,
    ST_RUN0   = 6'b00_0100,
    ST_EMIT0  = 6'b00_1000,
    ST_RUN1   = 6'b01_0000,
    ST_EMIT1  = 6'b10_0000
  } top_state_e;

  top_state_e state_q, state_d;
  logic       ovf_q, ovf_d;

  logic [CountW-1:0]      count_q, count_d;
  logic signed [SumW-1:0] sum_all_q, sum_all_d, sum_tail_q, sum_tail_d;
  logic [SumSqW-1:0]      sumsq_all_q, sumsq_all_d, sumsq_tail_q, sumsq_tail_d;
  logic [ScaleW-1:0]      scale_q;

  logic                   out_valid_q, out_valid_d;
  logic                   window_q, window_d, wvalid_q, wvalid_d, ovf_out_q, ovf_out_d;
  logic                   last_q, last_d;
  sms_res_t               ores_q, ores_d;

  logic                   in_acc, out_acc, out_free, tail_ok;
  logic [SampleW-1:0]     mag;
  logic [47:0]            sq;
  logic                   calc_start, win1, calc_done;
  logic [CountW-1:0]      calc_n;
  sms_res_t               calc_res;

  // hold the input while a word is in progress or an overflow word waits for the output register
  assign in_stall_o = (state_q != ST_IDLE) || ovf_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tail_ok    = count_q > CountW'(SkipCount);

  assign mag = sample_i[SampleW-1] ? SampleW'(-sample_i) : sample_i;
  assign sq  = {24'b0, mag} * {24'b0, mag};

  assign win1       = state_q == ST_EMIT0;
  assign calc_start = (state_q == ST_START0) || (win1 && out_free && tail_ok);
  assign calc_n     = win1 ? count_q - CountW'(SkipCount) : count_q;

  sms_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (calc_start),
    .n_i     (calc_n),
    .sum_i   (win1 ? sum_tail_q : sum_all_q),
    .sumsq_i (win1 ? sumsq_tail_q : sumsq_all_q),
    .scale_i (scale_q),
    .done_o  (calc_done),
    .res_o   (calc_res)
  );

  always_comb begin
    state_d = state_q;
    ovf_d = ovf_q;
    count_d = count_q;
    sum_all_d = sum_all_q; sumsq_all_d = sumsq_all_q;
    sum_tail_d = sum_tail_q; sumsq_tail_d = sumsq_tail_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    window_d = window_q; wvalid_d = wvalid_q; ovf_out_d = ovf_out_q;
    last_d = last_q; ores_d = ores_q;

    case (state_q)
      ST_IDLE: begin
        if (ovf_q && out_free) begin
          // refused sample: one overflow word
          out_valid_d = 1'b1;
          window_d = 1'b0; wvalid_d = 1'b0; ovf_out_d = 1'b1; last_d = 1'b1;
          ores_d = '0;
          ovf_d = 1'b0;
        end
        if (in_acc) begin
          if (opcode_i == OpClear) begin
            count_d = '0;
            sum_all_d = '0; sumsq_all_d = '0; sum_tail_d = '0; sumsq_tail_d = '0;
          end else if (count_q >= CountW'(MaxSamples)) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CountW'(1);
            sum_all_d = sum_all_q + SumW'(sample_i);
            sumsq_all_d = sumsq_all_q + SumSqW'(sq);
            if (count_q >= CountW'(SkipCount)) begin
              sum_tail_d = sum_tail_q + SumW'(sample_i);
              sumsq_tail_d = sumsq_tail_q + SumSqW'(sq);
            end
            state_d = ST_START0;
          end
        end
      end
      ST_START0: begin
        state_d = ST_RUN0;
      end
      ST_RUN0: begin
        if (calc_done) state_d = ST_EMIT0;
      end
      ST_EMIT0: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          window_d = 1'b0; wvalid_d = 1'b1; ovf_out_d = 1'b0; last_d = 1'b0;
          ores_d = calc_res;
          state_d = tail_ok ? ST_RUN1 : ST_EMIT1;
        end
      end
      ST_RUN1: begin
        if (calc_done) state_d = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          window_d = 1'b1; wvalid_d = tail_ok; ovf_out_d = 1'b0; last_d = 1'b1;
          ores_d = tail_ok ? calc_res : '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ovf_q        <= 1'b0;
      count_q      <= '0;
      sum_all_q    <= '0;
      sumsq_all_q  <= '0;
      sum_tail_q   <= '0;
      sumsq_tail_q <= '0;
      scale_q      <= ScaleReset;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ovf_q        <= ovf_d;
      count_q      <= count_d;
      sum_all_q    <= sum_all_d;
      sumsq_all_q  <= sumsq_all_d;
      sum_tail_q   <= sum_tail_d;
      sumsq_tail_q <= sumsq_tail_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q  <= window_d;
    wvalid_q  <= wvalid_d;
    ovf_out_q <= ovf_out_d;
    last_q    <= last_d;
    ores_q    <= ores_d;
  end

  assign out_valid_o    = out_valid_q;
  assign window_o       = window_q;
  assign window_valid_o = wvalid_q;
  assign overflow_o     = ovf_out_q;
  assign mean_o         = ores_q.mean;
  assign std_dev_o      = ores_q.std_dev;
  assign stability_o    = ores_q.stability;
  assign last_o         = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxSamples))
    else $error("sample count beyond store size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == OpClear) |=> (count_q == '0 && sum_all_q == '0))
    else $error("clear did not empty the sums");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |-> (state_q == ST_RUN0 || state_q == ST_RUN1))
    else $error("engine finished outside a run state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(ores_q))
    else $error("held result word was overwritten");

endmodule
